// ----- hw/rtl/frqp_pkg.sv -----
// Shared constants, codes and types for the flash ring queue pointer block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package frqp_pkg;

  localparam int SUBSECTION_BYTES  = 4096;
  localparam int SUB_LOG2          = 12;
  localparam int FLASH_SUBSECTIONS = 256;
  localparam int BASE_MAX          = FLASH_SUBSECTIONS - 3;
  localparam int REGION_BYTES      = 2 * SUBSECTION_BYTES;

  localparam int ADDR_W     = 20;
  localparam int PTR_W      = ADDR_W + 1;
  localparam int LEN_W      = 14;
  localparam int CNT_W      = 14;
  localparam int CMD_W      = 3;
  localparam int BATCH_W    = 16;
  localparam int BASE_W     = 8;
  localparam int ESL_W      = 3;
  localparam int ES_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_RESET = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENQ   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEQ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BATCH = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESL  = 2'd1;

  localparam logic [BASE_W-1:0] RST_BASE = 8'd0;
  localparam logic [ESL_W-1:0]  RST_ESL  = 3'd4;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_ERASE = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } mem_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COUNT,
    ST_SEND1,
    ST_SEND2
  } state_t;

  typedef struct packed {
    mem_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } slot_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic count;
    logic sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic two;
  } ctl_sts_t;

endpackage

// ----- hw/rtl/frqp_if.sv -----
// Valid/ready channel interfaces: command input, flash command output, register write.
// Depends on frqp_pkg for field widths.
interface frqp_in_if;
  logic                          valid;
  logic                          ready;
  logic [frqp_pkg::CMD_W-1:0]    cmd;
  logic [frqp_pkg::BATCH_W-1:0]  batch_count;
  modport source (output valid, cmd, batch_count, input ready);
  modport sink (input valid, cmd, batch_count, output ready);
endinterface

interface frqp_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mem_op;
  logic [frqp_pkg::ADDR_W-1:0]  mem_addr;
  logic [frqp_pkg::LEN_W-1:0]   mem_len;
  logic                         success;
  logic [frqp_pkg::CNT_W-1:0]   moved_count;
  logic [frqp_pkg::CNT_W-1:0]   stored_count;
  logic                         last;
  modport source (output valid, mem_op, mem_addr, mem_len, success, moved_count,
                  stored_count, last, input ready);
  modport sink (input valid, mem_op, mem_addr, mem_len, success, moved_count,
                stored_count, last, output ready);
endinterface

interface frqp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [frqp_pkg::CFG_IDX_W-1:0]  index;
  logic [frqp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/frqp_ctrl.sv -----
// Sequencer: takes a command word, runs update and count steps, sends one or two words.
// Depends on frqp_pkg.
module frqp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_last,
  output frqp_pkg::ctl_cmd_t ctl,
  input  frqp_pkg::ctl_sts_t sts
);
  import frqp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC:  state_next = ST_COUNT;
      ST_COUNT: state_next = ST_SEND1;
      ST_SEND1: begin
        if (out_ready) state_next = sts.two ? ST_SEND2 : ST_IDLE;
      end
      ST_SEND2: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    ctl       = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_EXEC:  ctl.exec = 1'b1;
      ST_COUNT: ctl.count = 1'b1;
      ST_SEND1: begin
        out_valid = 1'b1;
        out_last  = !sts.two;
      end
      ST_SEND2: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        ctl.sel   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/frqp_dp.sv -----
// Datapath: region registers, read/write pointers, wrapped flag, element count and result slots.
// Depends on frqp_pkg; driven by frqp_ctrl commands.
module frqp_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  frqp_pkg::ctl_cmd_t              ctl,
  output frqp_pkg::ctl_sts_t              sts,
  input  logic                            cfg_we,
  input  logic [frqp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frqp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [frqp_pkg::CMD_W-1:0]      cmd,
  input  logic [frqp_pkg::BATCH_W-1:0]    batch_count,
  output logic [1:0]                      mem_op,
  output logic [frqp_pkg::ADDR_W-1:0]     mem_addr,
  output logic [frqp_pkg::LEN_W-1:0]      mem_len,
  output logic                            success,
  output logic [frqp_pkg::CNT_W-1:0]      moved_count,
  output logic [frqp_pkg::CNT_W-1:0]      stored_count
);
  import frqp_pkg::*;

  function automatic logic [PTR_W-1:0] region_lo(input logic [BASE_W-1:0] b);
    logic [BASE_W:0] bc;
    bc = (b > BASE_W'(BASE_MAX)) ? (BASE_W+1)'(BASE_MAX) : {1'b0, b};
    return PTR_W'(bc + 9'd1) << SUB_LOG2;
  endfunction

  function automatic logic [PTR_W-1:0] wrap_rd(input logic [PTR_W-1:0] p,
                                               input logic [PTR_W-1:0] w,
                                               input logic [PTR_W-1:0] lo,
                                               input logic [PTR_W-1:0] hi);
    return (p >= hi && w != hi) ? lo : p;
  endfunction

  logic [ESL_W-1:0]   esl;
  logic [PTR_W-1:0]   lo;
  logic [PTR_W-1:0]   hi;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic               wrapped;
  logic [CNT_W-1:0]   stored;
  logic [CMD_W-1:0]   cmd_q;
  logic [BATCH_W-1:0] want;
  slot_t              slot0;
  slot_t              slot1;
  logic               two;
  logic               ok;
  logic [CNT_W-1:0]   moved;

  logic [PTR_W-1:0]   lo_new;
  logic [PTR_W-1:0]   rd_next;
  logic [PTR_W-1:0]   wr_next;
  logic               wrapped_next;
  slot_t              slot0_next;
  slot_t              slot1_next;
  logic               two_next;
  logic               ok_next;
  logic [CNT_W-1:0]   moved_next;
  logic [CNT_W-1:0]   stored_next;

  logic [ES_W-1:0]    es;
  logic [PTR_W-1:0]   es_p;
  logic               empty;
  logic               at_end;
  logic               wr_wrap;
  logic [PTR_W-1:0]   w1;
  logic [PTR_W-1:0]   r1;
  logic               wr1;
  logic               erase;
  logic [PTR_W-1:0]   sub;
  logic [PTR_W-1:0]   nxt;
  logic [CNT_W-1:0]   have;
  logic [CNT_W-1:0]   cnt;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   first;
  logic [LEN_W-1:0]   rest;
  logic [PTR_W-1:0]   r_mid;
  logic [PTR_W-1:0]   diff;

  assign es   = ES_W'(1) << esl;
  assign es_p = PTR_W'(es);
  assign hi   = lo + PTR_W'(REGION_BYTES);
  assign sts.two = two;

  assign lo_new = (cfg_index == REG_BASE) ? region_lo(cfg_data) : lo;

  always_comb begin
    diff = wr_ptr - rd_ptr;
    if (wr_ptr >= rd_ptr) begin
      stored_next = CNT_W'(diff) >> esl;
    end else begin
      stored_next = (CNT_W'(REGION_BYTES) - CNT_W'(rd_ptr - wr_ptr)) >> esl;
    end
  end

  always_comb begin
    empty   = (rd_ptr == wr_ptr);
    at_end  = (rd_ptr == hi) && (wr_ptr == hi);
    wr_wrap = (wr_ptr + es_p) > hi;
    w1      = wr_wrap ? lo : wr_ptr;
    wr1     = wr_wrap | wrapped;
    r1      = (wr_wrap && at_end) ? lo : rd_ptr;
    erase   = w1[SUB_LOG2-1:0] < SUB_LOG2'(es);
    sub     = {w1[PTR_W-1:SUB_LOG2], {SUB_LOG2{1'b0}}};
    nxt     = sub + PTR_W'(SUBSECTION_BYTES);
    have    = empty ? '0 : stored;
    cnt     = ({2'b00, have} < want) ? have : want[CNT_W-1:0];
    len     = LEN_W'(cnt) << esl;
    first   = LEN_W'(hi - rd_ptr);
    rest    = len - first;
    r_mid   = wrap_rd(hi, wr_ptr, lo, hi);

    rd_next      = rd_ptr;
    wr_next      = wr_ptr;
    wrapped_next = wrapped;
    slot0_next   = '{op: OP_NONE, addr: '0, len: '0};
    slot1_next   = '{op: OP_NONE, addr: '0, len: '0};
    two_next     = 1'b0;
    ok_next      = 1'b1;
    moved_next   = '0;

    case (cmd_q)
      CMD_RESET: begin
        rd_next      = lo;
        wr_next      = lo;
        wrapped_next = 1'b0;
      end
      CMD_ENQ: begin
        wrapped_next = wr1;
        wr_next      = w1 + es_p;
        rd_next      = r1;
        slot1_next   = '{op: OP_WRITE, addr: ADDR_W'(w1), len: LEN_W'(es)};
        if (erase) begin
          two_next   = 1'b1;
          slot0_next = '{op: OP_ERASE, addr: ADDR_W'(sub), len: '0};
          if (wr1 && !at_end && r1 >= sub && r1 < nxt) begin
            rd_next = wrap_rd(nxt, w1, lo, hi);
          end
        end else begin
          slot0_next = slot1_next;
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (empty) begin
          ok_next = 1'b0;
        end else begin
          slot0_next = '{op: OP_READ, addr: ADDR_W'(rd_ptr), len: LEN_W'(es)};
          if (cmd_q == CMD_DEQ) begin
            rd_next = wrap_rd(rd_ptr + es_p, wr_ptr, lo, hi);
          end
        end
      end
      CMD_BATCH: begin
        if (cnt != '0) begin
          moved_next = cnt;
          if ((rd_ptr + PTR_W'(len)) > hi) begin
            two_next   = 1'b1;
            slot0_next = '{op: OP_READ, addr: ADDR_W'(rd_ptr), len: first};
            slot1_next = '{op: OP_READ, addr: ADDR_W'(r_mid), len: rest};
            rd_next    = wrap_rd(r_mid + PTR_W'(rest), wr_ptr, lo, hi);
          end else begin
            slot0_next = '{op: OP_READ, addr: ADDR_W'(rd_ptr), len: len};
            rd_next    = wrap_rd(rd_ptr + PTR_W'(len), wr_ptr, lo, hi);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esl     <= RST_ESL;
      lo      <= region_lo(RST_BASE);
      rd_ptr  <= region_lo(RST_BASE);
      wr_ptr  <= region_lo(RST_BASE);
      wrapped <= 1'b0;
      stored  <= '0;
    end else if (cfg_we && (cfg_index == REG_BASE || cfg_index == REG_ESL)) begin
      if (cfg_index == REG_ESL) esl <= cfg_data[ESL_W-1:0];
      lo      <= lo_new;
      rd_ptr  <= lo_new;
      wr_ptr  <= lo_new;
      wrapped <= 1'b0;
      stored  <= '0;
    end else if (ctl.exec) begin
      rd_ptr  <= rd_next;
      wr_ptr  <= wr_next;
      wrapped <= wrapped_next;
    end else if (ctl.count) begin
      stored <= stored_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
      want  <= batch_count;
    end
    if (ctl.exec) begin
      slot0 <= slot0_next;
      slot1 <= slot1_next;
      two   <= two_next;
      ok    <= ok_next;
      moved <= moved_next;
    end
  end

  always_comb begin
    mem_op       = ctl.sel ? slot1.op : slot0.op;
    mem_addr     = ctl.sel ? slot1.addr : slot0.addr;
    mem_len      = ctl.sel ? slot1.len : slot0.len;
    success      = ok;
    moved_count  = moved;
    stored_count = stored;
  end

endmodule

// ----- hw/rtl/flash_ring_queue_pointers.sv -----
// Flash ring queue pointers: takes a command word, updates the pointers, then recounts.
// The first result word is sent after the recount; a command with two words sends one more.
// The controller takes one command at a time and accepts no new one until its last result
// word is taken; rsp not ready stalls it. Synchronous active-high reset puts the
// region at base subsection 0, element size 16 bytes, both pointers at region start, unwrapped.
module flash_ring_queue_pointers (
  input logic       clk,
  input logic       rst,
  frqp_in_if.sink   req,
  frqp_out_if.source rsp,
  frqp_cfg_if.sink  cfg
);
  import frqp_pkg::*;

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  assign cfg.ready = 1'b1;

  frqp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_last  (rsp.last),
    .ctl       (ctl),
    .sts       (sts)
  );

  frqp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cfg_we       (cfg.valid && cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .cmd          (req.cmd),
    .batch_count  (req.batch_count),
    .mem_op       (rsp.mem_op),
    .mem_addr     (rsp.mem_addr),
    .mem_len      (rsp.mem_len),
    .success      (rsp.success),
    .moved_count  (rsp.moved_count),
    .stored_count (rsp.stored_count)
  );

  a_no_take_while_sending: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("command taken while a result word is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && rsp.last |=> req.ready && !rsp.valid)
    else $error("not idle after final result word");

  a_none_is_blank: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.mem_op == OP_NONE |-> rsp.mem_addr == '0 && rsp.mem_len == '0)
    else $error("no-op word carries address or length");

  a_not_last_is_split: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.last |-> rsp.mem_op == OP_ERASE || rsp.mem_op == OP_READ)
    else $error("first of two words is neither erase nor split read");

endmodule

// ----- tb/flash_ring_queue_pointers_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for flash_ring_queue_pointers: drives commands and register
// writes, predicts each flash command word and compares it. Needs frqp_pkg and frqp_if.
module flash_ring_queue_pointers_tb;
  import frqp_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 600000;

  localparam logic [CMD_W-1:0]     CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0]     CMD_RSVD_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  typedef enum int {FILL, DRAIN, MIXED, NOISE} traffic_t;

  typedef struct {
    mem_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              success;
    logic [CNT_W-1:0]  moved;
    logic [CNT_W-1:0]  stored;
    logic              last;
  } flash_word_t;

  logic clk = 1'b0;
  logic rst;

  frqp_in_if  req_ch ();
  frqp_out_if rsp_ch ();
  frqp_cfg_if cfg_ch ();

  flash_ring_queue_pointers dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // queue geometry and pointer state as the block should hold it
  logic [BASE_W-1:0] cfg_base;
  logic [ESL_W-1:0]  cfg_esl;
  int unsigned       head_addr;
  int unsigned       tail_addr;
  logic              has_lapped;

  flash_word_t flash_words_due[$];
  int          word_errors  = 0;
  int unsigned cycle_count  = 0;
  int          src_idle_pct = 18;
  int          snk_idle_pct = 78;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL flash_ring_queue_pointers");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic int unsigned region_start();
    int unsigned b;
    b = (cfg_base > BASE_MAX) ? BASE_MAX : cfg_base;
    return (b + 1) * SUBSECTION_BYTES;
  endfunction

  function automatic int unsigned elems_held();
    if (tail_addr >= head_addr) return (tail_addr - head_addr) >> cfg_esl;
    return (REGION_BYTES - (head_addr - tail_addr)) >> cfg_esl;
  endfunction

  function automatic void wrap_head(int unsigned lo, int unsigned hi);
    if (head_addr >= hi && tail_addr != hi) head_addr = lo;
  endfunction

  function automatic void rewind_pointers();
    head_addr  = region_start();
    tail_addr  = head_addr;
    has_lapped = 1'b0;
  endfunction

  function automatic flash_word_t flash_word(mem_op_t op, int unsigned addr, int unsigned len);
    flash_word_t w;
    w.op      = op;
    w.addr    = addr[ADDR_W-1:0];
    w.len     = len[LEN_W-1:0];
    w.success = 1'b0;
    w.moved   = '0;
    w.stored  = '0;
    w.last    = 1'b0;
    return w;
  endfunction

  function automatic void predict_flash_words(logic [CMD_W-1:0] c, logic [BATCH_W-1:0] want);
    flash_word_t words[$];
    int unsigned es, lo, hi, sub, have, cnt, len, first, moved, held;
    logic        ok;
    logic        empty_at_end;
    es    = 1 << cfg_esl;
    lo    = region_start();
    hi    = lo + REGION_BYTES;
    ok    = 1'b1;
    moved = 0;
    case (c)
      CMD_RESET: begin
        rewind_pointers();
        words.push_back(flash_word(OP_NONE, 0, 0));
      end
      CMD_ENQ: begin
        empty_at_end = (head_addr == hi) && (tail_addr == hi);
        if (tail_addr + es > hi) begin
          tail_addr  = lo;
          has_lapped = 1'b1;
          if (empty_at_end) head_addr = lo;
        end
        if (tail_addr % SUBSECTION_BYTES < es) begin
          sub = tail_addr - tail_addr % SUBSECTION_BYTES;
          words.push_back(flash_word(OP_ERASE, sub, 0));
          if (has_lapped && !empty_at_end && head_addr >= sub &&
              head_addr < sub + SUBSECTION_BYTES) begin
            head_addr = sub + SUBSECTION_BYTES;
            wrap_head(lo, hi);
          end
        end
        words.push_back(flash_word(OP_WRITE, tail_addr, es));
        tail_addr += es;
      end
      CMD_DEQ, CMD_PEEK: begin
        if (head_addr == tail_addr) begin
          ok = 1'b0;
          words.push_back(flash_word(OP_NONE, 0, 0));
        end else begin
          words.push_back(flash_word(OP_READ, head_addr, es));
          if (c == CMD_DEQ) begin
            head_addr += es;
            wrap_head(lo, hi);
          end
        end
      end
      CMD_BATCH: begin
        have = (head_addr == tail_addr) ? 0 : elems_held();
        cnt  = (want < have) ? want : have;
        if (cnt == 0) begin
          words.push_back(flash_word(OP_NONE, 0, 0));
        end else begin
          len = cnt << cfg_esl;
          if (head_addr + len > hi) begin
            first = hi - head_addr;
            words.push_back(flash_word(OP_READ, head_addr, first));
            head_addr = hi;
            wrap_head(lo, hi);
            words.push_back(flash_word(OP_READ, head_addr, len - first));
            head_addr += len - first;
          end else begin
            words.push_back(flash_word(OP_READ, head_addr, len));
            head_addr += len;
          end
          wrap_head(lo, hi);
          moved = cnt;
        end
      end
      default: begin
        words.push_back(flash_word(OP_NONE, 0, 0));
      end
    endcase
    held = elems_held();
    foreach (words[k]) begin
      words[k].success = ok;
      words[k].moved   = moved[CNT_W-1:0];
      words[k].stored  = held[CNT_W-1:0];
      words[k].last    = (k == words.size() - 1);
      flash_words_due.push_back(words[k]);
    end
  endfunction

  always @(posedge clk) begin : check_words
    flash_word_t due;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (flash_words_due.size() == 0) begin
        $error("unexpected word: mem_op %0d mem_addr 0x%0h mem_len %0d",
               rsp_ch.mem_op, rsp_ch.mem_addr, rsp_ch.mem_len);
        word_errors++;
      end else begin
        due = flash_words_due.pop_front();
        if (rsp_ch.mem_op !== due.op) begin
          $error("mem_op: expected %0d, got %0d", due.op, rsp_ch.mem_op);
          word_errors++;
        end
        if (rsp_ch.mem_addr !== due.addr) begin
          $error("mem_addr: expected 0x%0h, got 0x%0h", due.addr, rsp_ch.mem_addr);
          word_errors++;
        end
        if (rsp_ch.mem_len !== due.len) begin
          $error("mem_len: expected %0d, got %0d", due.len, rsp_ch.mem_len);
          word_errors++;
        end
        if (rsp_ch.success !== due.success) begin
          $error("success: expected %0d, got %0d", due.success, rsp_ch.success);
          word_errors++;
        end
        if (rsp_ch.moved_count !== due.moved) begin
          $error("moved_count: expected %0d, got %0d", due.moved, rsp_ch.moved_count);
          word_errors++;
        end
        if (rsp_ch.stored_count !== due.stored) begin
          $error("stored_count: expected %0d, got %0d", due.stored, rsp_ch.stored_count);
          word_errors++;
        end
        if (rsp_ch.last !== due.last) begin
          $error("last: expected %0d, got %0d", due.last, rsp_ch.last);
          word_errors++;
        end
      end
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [BATCH_W-1:0] n);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= c;
    req_ch.batch_count <= n;
    do @(posedge clk); while (!req_ch.ready);
    predict_flash_words(c, n);
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (flash_words_due.size() != 0);
  endtask

  task automatic wait_idle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_BASE) begin
      cfg_base = d;
      rewind_pointers();
    end else if (idx == REG_ESL) begin
      cfg_esl = d[ESL_W-1:0];
      rewind_pointers();
    end
  endtask

  task automatic set_region(input logic [BASE_W-1:0] base, input logic [ESL_W-1:0] esl);
    logic [CFG_DATA_W-1:0] d;
    write_reg(REG_BASE, base);
    d            = $urandom;
    d[ESL_W-1:0] = esl;
    write_reg(REG_ESL, d);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd(traffic_t mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      FILL:  return (r < 88) ? CMD_ENQ : (r < 94) ? CMD_DEQ : CMD_BATCH;
      DRAIN: return (r < 45) ? CMD_DEQ : (r < 75) ? CMD_BATCH : (r < 90) ? CMD_PEEK : CMD_ENQ;
      MIXED: begin
        if (r < 45) return CMD_ENQ;
        if (r < 70) return CMD_DEQ;
        if (r < 80) return CMD_PEEK;
        if (r < 95) return CMD_BATCH;
        if (r < 97) return CMD_RESET;
        return CMD_RSVD_LO + CMD_W'($urandom_range(CMD_RSVD_HI - CMD_RSVD_LO));
      end
      default: return CMD_W'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [BATCH_W-1:0] pick_batch();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return BATCH_W'($urandom);
      3:       return BATCH_W'($urandom_range(1, 300));
      default: return BATCH_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic test_empty_and_reserved();
    send_cmd(CMD_PEEK, 16'($urandom));
    send_cmd(CMD_DEQ, 16'($urandom));
    send_cmd(CMD_BATCH, 16'd5);
    send_cmd(CMD_RSVD_LO, 16'hFFFF);
    send_cmd(CMD_RSVD_HI, 16'h0000);
    send_cmd(CMD_RESET, 16'($urandom));
  endtask

  task automatic test_field_extremes();
    send_cmd(CMD_ENQ, 16'h0000);
    send_cmd(CMD_ENQ, 16'hFFFF);
    send_cmd(CMD_PEEK, 16'($urandom));
    send_cmd(CMD_BATCH, 16'h0000);
    send_cmd(CMD_BATCH, 16'hFFFF);
    send_cmd(CMD_DEQ, 16'($urandom));
    send_cmd(CMD_RESET, 16'($urandom));
    send_cmd(CMD_ENQ, 16'($urandom));
    send_cmd(CMD_DEQ, 16'($urandom));
    wait_idle();
    // no register behind this index: pointers must stay put
    write_reg(REG_UNUSED, 8'hFF);
    set_region(8'hFF, 3'd0);
    send_cmd(CMD_ENQ, 16'($urandom));
    send_cmd(CMD_ENQ, 16'($urandom));
    send_cmd(CMD_BATCH, 16'd1);
    send_cmd(CMD_PEEK, 16'($urandom));
    send_cmd(CMD_RESET, 16'($urandom));
    wait_idle();
    set_region(8'd254, 3'd7);
    send_cmd(CMD_ENQ, 16'($urandom));
    send_cmd(CMD_BATCH, 16'hFFFF);
  endtask

  task automatic test_wrap_and_overwrite();
    int fill;
    wait_idle();
    set_region(BASE_W'($urandom_range(255)), 3'd7);
    fill = REGION_BYTES >> 7;
    // fill the region, then lap it so the erase drops the oldest subsection
    repeat (fill + 1) send_cmd(CMD_ENQ, 16'($urandom));
    send_cmd(CMD_BATCH, 16'hFFFF);
    send_cmd(CMD_RESET, 16'($urandom));
    // drain to the region end with the write side there too
    repeat (fill) send_cmd(CMD_ENQ, 16'($urandom));
    repeat (fill) send_cmd(CMD_DEQ, 16'($urandom));
    send_cmd(CMD_PEEK, 16'($urandom));
    send_cmd(CMD_BATCH, 16'd3);
    // push past the read side until the pointers meet
    repeat (fill + 6) send_cmd(CMD_ENQ, 16'($urandom));
    send_cmd(CMD_PEEK, 16'($urandom));
    send_cmd(CMD_DEQ, 16'($urandom));
    send_cmd(CMD_BATCH, 16'hFFFF);
  endtask

  task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct,
                                     input logic [BASE_W-1:0] base,
                                     input logic [ESL_W-1:0] esl);
    traffic_t         mode;
    int               burst;
    int               left;
    logic [CMD_W-1:0] c;
    wait_idle();
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    set_region(base, esl);
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(9))
        0, 1, 2, 3: mode = FILL;
        4, 5:       mode = DRAIN;
        6, 7, 8:    mode = MIXED;
        default:    mode = NOISE;
      endcase
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) begin
        c = pick_cmd(mode);
        if ($urandom_range(79) == 0) hold_until_drained();
        send_cmd(c, pick_batch());
      end
      left -= burst;
    end
  endtask

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_RESET;
    req_ch.batch_count <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_BASE;
    cfg_ch.data        <= '0;
    cfg_base = RST_BASE;
    cfg_esl  = RST_ESL;
    rewind_pointers();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_reserved();
    test_field_extremes();
    test_wrap_and_overwrite();
    test_random_traffic(500, 18, 78, BASE_W'($urandom_range(253, 255)), 3'd7);
    test_random_traffic(500, 78, 18, 8'd0, 3'd6);
    test_random_traffic(250, 0, 0, BASE_W'($urandom), 3'd5);
    test_random_traffic(230, 0, 0, BASE_W'($urandom), ESL_W'($urandom_range(7)));
    wait_idle();

    if (word_errors == 0) $display("PASS flash_ring_queue_pointers");
    else $display("FAIL flash_ring_queue_pointers");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/frqp_pkg.sv
hw/rtl/frqp_if.sv
hw/rtl/frqp_ctrl.sv
hw/rtl/frqp_dp.sv
hw/rtl/flash_ring_queue_pointers.sv
tb/flash_ring_queue_pointers_tb.sv
